// ===== src/mpct_pkg.sv =====
// mouse pointer click tracker: shared constants, register codes and item types
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package mpct_pkg;

	// defaults for the top level parameters
	localparam int BUTTONS_DEF       = 5;
	localparam int FRACTION_BITS_DEF = 8;

	// fixed field widths
	localparam int MASK_W     = 5;
	localparam int COORD_W    = 12;
	localparam int GAIN_W     = 16;
	localparam int MOVE_W     = 8;
	localparam int TIME_W     = 32;
	localparam int WINDOW_W   = 16;
	localparam int GAIN_FRAC  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register reset values
	localparam logic [COORD_W-1:0]  MAX_X_RST       = 12'd720;
	localparam logic [COORD_W-1:0]  MAX_Y_RST       = 12'd576;
	localparam logic [GAIN_W-1:0]   GAIN_RST        = 16'd256;
	localparam logic [WINDOW_W-1:0] DOUBLE_CLICK_RST = 16'd500;
	localparam logic [TIME_W-1:0]   IDLE_LIMIT_RST  = 32'd5000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_X        = 3'd0,
		REG_MAX_Y        = 3'd1,
		REG_GAIN_X       = 3'd2,
		REG_GAIN_Y       = 3'd3,
		REG_DOUBLE_CLICK = 3'd4,
		REG_IDLE_LIMIT   = 3'd5
	} cfg_reg_t;

	// one polled mouse report
	typedef struct packed {
		logic [TIME_W-1:0]        packet_number;
		logic signed [MOVE_W-1:0] move_x;
		logic signed [MOVE_W-1:0] move_y;
		logic signed [MOVE_W-1:0] wheel;
		logic [MASK_W-1:0]        button_bits;
		logic [TIME_W-1:0]        now_ms;
	} report_t;

	// one tracker result
	typedef struct packed {
		logic [COORD_W-1:0]       pointer_x;
		logic [COORD_W-1:0]       pointer_y;
		logic signed [MOVE_W-1:0] delta_x;
		logic signed [MOVE_W-1:0] delta_y;
		logic signed [MOVE_W-1:0] wheel_delta;
		logic [MASK_W-1:0]        down_mask;
		logic [MASK_W-1:0]        click_mask;
		logic [MASK_W-1:0]        double_click_mask;
		logic [MASK_W-1:0]        hold_mask;
		logic                     active;
		logic                     pointer_reset_request;
	} result_t;

	// per-button event flags from the button unit
	typedef struct packed {
		logic [MASK_W-1:0] click;
		logic [MASK_W-1:0] dbl;
		logic [MASK_W-1:0] hold;
		logic              quiet;
	} btn_flags_t;

endpackage

`default_nettype wire

// ===== src/mpct_if.sv =====
// mouse pointer click tracker: valid/ready channels for reports and results
// depends on mpct_pkg for the item types
`default_nettype none

interface mpct_report_if;
	logic              valid;
	logic              ready;
	mpct_pkg::report_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mpct_result_if;
	logic              valid;
	logic              ready;
	mpct_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/mpct_axis.sv =====
// mouse pointer click tracker: one pointer axis, gain scaling, add and clamp
// holds the fixed-point position register; depends on mpct_pkg
`default_nettype none

module mpct_axis #(
	parameter int FRACTION_BITS = mpct_pkg::FRACTION_BITS_DEF,
	parameter logic [mpct_pkg::COORD_W-1:0] RESET_MAX = mpct_pkg::MAX_X_RST
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               step,
	input  wire logic                               recentre,
	input  wire logic signed [mpct_pkg::MOVE_W-1:0] move,
	input  wire logic [mpct_pkg::GAIN_W-1:0]        gain,
	input  wire logic [mpct_pkg::COORD_W-1:0]       lim_max,
	input  wire logic [mpct_pkg::COORD_W-1:0]       centre_max,
	output logic [mpct_pkg::COORD_W-1:0]            coord
);

	localparam int POS_W  = mpct_pkg::COORD_W + FRACTION_BITS;
	localparam int PROD_W = mpct_pkg::MOVE_W + mpct_pkg::GAIN_W + 1;
	localparam int UP     = (FRACTION_BITS >= mpct_pkg::GAIN_FRAC) ?
		FRACTION_BITS - mpct_pkg::GAIN_FRAC : 0;
	localparam int DN     = (FRACTION_BITS >= mpct_pkg::GAIN_FRAC) ?
		0 : mpct_pkg::GAIN_FRAC - FRACTION_BITS;
	localparam int SCL_W  = PROD_W + UP;
	localparam int SUM_W  = ((POS_W + 1 > SCL_W) ? POS_W + 1 : SCL_W) + 1;
	localparam logic [POS_W-1:0] RESET_POS = POS_W'((POS_W'(RESET_MAX) << FRACTION_BITS) >> 1);

	logic [POS_W-1:0]        pos_q;
	logic [POS_W-1:0]        pos_adv;
	logic [POS_W-1:0]        pos_next;
	logic [POS_W-1:0]        centre_pos;
	logic signed [PROD_W-1:0] prod;
	logic signed [SCL_W-1:0]  scaled;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  lim;

	// motion times Q8.8 gain, aligned to the position fraction (floor on right shift)
	assign prod   = move * $signed({1'b0, gain});
	assign scaled = (SCL_W'(prod) <<< UP) >>> DN;

	// add and clamp to 0..max
	assign sum = SUM_W'(scaled) + $signed(SUM_W'(pos_q));
	assign lim = $signed(SUM_W'(lim_max) << FRACTION_BITS);

	always_comb begin
		priority if (sum < 0) begin
			pos_adv = '0;
		end else if (sum > lim) begin
			pos_adv = POS_W'(lim);
		end else begin
			pos_adv = POS_W'(sum);
		end
	end

	assign centre_pos = POS_W'((POS_W'(centre_max) << FRACTION_BITS) >> 1);
	assign pos_next   = step ? pos_adv : pos_q;
	assign coord      = pos_next[FRACTION_BITS +: mpct_pkg::COORD_W];

	// position register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= RESET_POS;
		end else if (recentre) begin
			pos_q <= centre_pos;
		end else if (step) begin
			pos_q <= pos_adv;
		end
	end

endmodule

`default_nettype wire

// ===== src/mpct_buttons.sv =====
// mouse pointer click tracker: per-button click, double click and hold events
// holds previous button state and release times; depends on mpct_pkg
`default_nettype none

module mpct_buttons #(
	parameter int BUTTONS = mpct_pkg::BUTTONS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic [mpct_pkg::MASK_W-1:0]    down,
	input  wire logic [mpct_pkg::TIME_W-1:0]    now_ms,
	input  wire logic [mpct_pkg::WINDOW_W-1:0]  window,
	output mpct_pkg::btn_flags_t                flags
);

	// buttons past the report width never go down
	localparam int ACT = (BUTTONS < mpct_pkg::MASK_W) ? BUTTONS : mpct_pkg::MASK_W;

	logic [mpct_pkg::MASK_W-1:0] prev_down_q;
	logic [mpct_pkg::TIME_W-1:0] rel_q [ACT];
	logic [mpct_pkg::MASK_W-1:0] busy;

	// event decode per button
	always_comb begin
		flags = '0;
		busy  = '0;
		for (int i = 0; i < ACT; i++) begin
			busy[i]       = down[i] | prev_down_q[i];
			flags.hold[i] = down[i] & prev_down_q[i];
			flags.click[i] = ~down[i] & prev_down_q[i];
			flags.dbl[i]  = down[i] & ~prev_down_q[i] &
				((now_ms - rel_q[i]) < mpct_pkg::TIME_W'(window));
		end
		flags.quiet = ~|busy;
	end

	// previous state and release stamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_down_q <= '0;
			for (int i = 0; i < ACT; i++) begin
				rel_q[i] <= '0;
			end
		end else if (step) begin
			prev_down_q <= down;
			for (int i = 0; i < ACT; i++) begin
				if (~down[i] & prev_down_q[i]) begin
					rel_q[i] <= now_ms;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/mouse_pointer_click_tracker.sv =====
// mouse pointer click tracker, top level: input register, one step of
// tracking logic, result register. throughput one item per cycle while the
// result side takes items; a stall on result.ready holds stage 1.
// reset is asynchronous: registers take their defaults, the pointer is centred,
// packet, buttons, release times and activity clear. depends on mpct_pkg, mpct_if
`default_nettype none

module mouse_pointer_click_tracker #(
	parameter int BUTTONS       = mpct_pkg::BUTTONS_DEF,
	parameter int FRACTION_BITS = mpct_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	mpct_report_if.sink                           report,
	mpct_result_if.source                         result,
	input  wire logic                             cfg_we,
	input  wire logic [mpct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mpct_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	logic [mpct_pkg::COORD_W-1:0]  max_x_q, max_y_q;
	logic [mpct_pkg::GAIN_W-1:0]   gain_x_q, gain_y_q;
	logic [mpct_pkg::WINDOW_W-1:0] dbl_window_q;
	logic [mpct_pkg::TIME_W-1:0]   idle_limit_q;

	logic [mpct_pkg::COORD_W-1:0]  max_x_next, max_y_next;
	logic                          recentre;

	// pipeline and state
	logic                          s1_valid_q;
	mpct_pkg::report_t             data_s1;
	logic                          res_valid_q;
	mpct_pkg::result_t             res_q;
	logic [mpct_pkg::TIME_W-1:0]   last_packet_q;
	logic [mpct_pkg::MASK_W-1:0]   report_buttons_q;
	logic [mpct_pkg::TIME_W-1:0]   last_active_q;
	logic                          active_q;

	logic                          advance;
	logic                          new_pkt;
	logic                          go_idle;
	logic                          active_next;
	logic [mpct_pkg::MASK_W-1:0]   down_now;
	logic [mpct_pkg::COORD_W-1:0]  coord_x, coord_y;
	mpct_pkg::btn_flags_t          flags;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q      <= mpct_pkg::MAX_X_RST;
			max_y_q      <= mpct_pkg::MAX_Y_RST;
			gain_x_q     <= mpct_pkg::GAIN_RST;
			gain_y_q     <= mpct_pkg::GAIN_RST;
			dbl_window_q <= mpct_pkg::DOUBLE_CLICK_RST;
			idle_limit_q <= mpct_pkg::IDLE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (mpct_pkg::cfg_reg_t'(cfg_index))
				mpct_pkg::REG_MAX_X:        max_x_q      <= cfg_data[mpct_pkg::COORD_W-1:0];
				mpct_pkg::REG_MAX_Y:        max_y_q      <= cfg_data[mpct_pkg::COORD_W-1:0];
				mpct_pkg::REG_GAIN_X:       gain_x_q     <= cfg_data[mpct_pkg::GAIN_W-1:0];
				mpct_pkg::REG_GAIN_Y:       gain_y_q     <= cfg_data[mpct_pkg::GAIN_W-1:0];
				mpct_pkg::REG_DOUBLE_CLICK: dbl_window_q <= cfg_data[mpct_pkg::WINDOW_W-1:0];
				mpct_pkg::REG_IDLE_LIMIT:   idle_limit_q <= cfg_data[mpct_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// a max write recentres both axes against the new limits
	always_comb begin
		max_x_next = max_x_q;
		max_y_next = max_y_q;
		recentre   = 1'b0;
		if (cfg_we) begin
			if (cfg_index == mpct_pkg::REG_MAX_X) begin
				max_x_next = cfg_data[mpct_pkg::COORD_W-1:0];
				recentre   = 1'b1;
			end
			if (cfg_index == mpct_pkg::REG_MAX_Y) begin
				max_y_next = cfg_data[mpct_pkg::COORD_W-1:0];
				recentre   = 1'b1;
			end
		end
	end

	// handshake: stage 1 moves on when the result register is free or draining
	assign advance      = s1_valid_q & (~res_valid_q | result.ready);
	assign report.ready = ~s1_valid_q | advance;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (report.ready) begin
			s1_valid_q <= report.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (report.valid && report.ready) begin
			data_s1 <= report.data;
		end
	end

	// new report detection and activity timer
	assign new_pkt  = data_s1.packet_number != last_packet_q;
	assign down_now = new_pkt ? data_s1.button_bits : report_buttons_q;
	assign go_idle  = (data_s1.now_ms - last_active_q) > idle_limit_q;

	always_comb begin
		priority if (new_pkt) begin
			active_next = 1'b1;
		end else if (go_idle) begin
			active_next = 1'b0;
		end else begin
			active_next = active_q;
		end
	end

	// report state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_packet_q    <= '0;
			report_buttons_q <= '0;
			last_active_q    <= '0;
			active_q         <= 1'b0;
		end else if (advance) begin
			active_q <= active_next;
			if (new_pkt) begin
				last_packet_q    <= data_s1.packet_number;
				report_buttons_q <= data_s1.button_bits;
				last_active_q    <= data_s1.now_ms;
			end
		end
	end

	// pointer axes
	mpct_axis #(
		.FRACTION_BITS (FRACTION_BITS),
		.RESET_MAX     (mpct_pkg::MAX_X_RST)
	) u_axis_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance & new_pkt),
		.recentre   (recentre),
		.move       (data_s1.move_x),
		.gain       (gain_x_q),
		.lim_max    (max_x_q),
		.centre_max (max_x_next),
		.coord      (coord_x)
	);

	mpct_axis #(
		.FRACTION_BITS (FRACTION_BITS),
		.RESET_MAX     (mpct_pkg::MAX_Y_RST)
	) u_axis_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance & new_pkt),
		.recentre   (recentre),
		.move       (data_s1.move_y),
		.gain       (gain_y_q),
		.lim_max    (max_y_q),
		.centre_max (max_y_next),
		.coord      (coord_y)
	);

	// button events
	mpct_buttons #(
		.BUTTONS (BUTTONS)
	) u_buttons (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.down   (down_now),
		.now_ms (data_s1.now_ms),
		.window (dbl_window_q),
		.flags  (flags)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.pointer_x             <= coord_x;
			res_q.pointer_y             <= coord_y;
			res_q.delta_x               <= new_pkt ? data_s1.move_x : '0;
			res_q.delta_y               <= new_pkt ? data_s1.move_y : '0;
			res_q.wheel_delta           <= new_pkt ? data_s1.wheel : '0;
			res_q.down_mask             <= down_now;
			res_q.click_mask            <= flags.click;
			res_q.double_click_mask     <= flags.dbl;
			res_q.hold_mask             <= flags.hold;
			res_q.active                <= active_next;
			res_q.pointer_reset_request <= flags.quiet;
		end
	end

	// checks on the tracking logic
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(s1_valid_q))
		else $error("result appeared without an item in stage 1");

	a_click_not_down: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.down_mask & res_q.click_mask) == '0)
		else $error("button both down and clicked");

	a_hold_dbl_down: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_q.hold_mask | res_q.double_click_mask) & ~res_q.down_mask) == '0)
		else $error("hold or double click on a button that is up");

	a_reset_req_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.pointer_reset_request |->
			(res_q.click_mask | res_q.hold_mask) == '0)
		else $error("pointer reset request while buttons active");

endmodule

`default_nettype wire
